[rtl/lsac_pkg.sv]
// Shared constants, codes and types for the logistic score accuracy counter.
// Used by lsac_csr, lsac_ctrl, lsac_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package lsac_pkg;

   localparam int FEATURE_WIDTH    = 16;
   localparam int COUNT_WIDTH      = 16;
   localparam int WEIGHT_WIDTH     = 16;
   localparam int WEIGHTS_PER_WORD = 4;
   localparam int CSR_WIDTH        = 64;
   localparam int CSR_INDEX_W      = 2;
   localparam int FCOUNT_W         = 4;
   localparam int ACC_WIDTH        = 40;
   localparam int MAX_FEATURES     = 12;
   localparam int POS_W            = 4;
   localparam int SCORE_W          = 24;

   localparam logic [FCOUNT_W-1:0] FEATURE_COUNT_RESET = FCOUNT_W'(9);

   // Stream payload widths, rounded up to whole bytes
   localparam int REQ_DATA_W   = ((FEATURE_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = SCORE_W + 1 + 2 * COUNT_WIDTH;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WEIGHT_LOW    = 2'd0,
      CSR_WEIGHT_MID    = 2'd1,
      CSR_WEIGHT_HIGH   = 2'd2,
      CSR_FEATURE_COUNT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CSR_WIDTH-1:0] weight_low;
      logic [CSR_WIDTH-1:0] weight_mid;
      logic [CSR_WIDTH-1:0] weight_high;
      logic [FCOUNT_W-1:0]  feature_count;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mac;
      logic sat;
      logic square;
      logic cube;
      logic linear;
      logic cterm;
      logic score;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic row_last;
      logic out_free;
   } status_type;

endpackage

[rtl/lsac_csr.sv]
// Configuration register bank: three packed weight words and the feature count.
// Depends on lsac_pkg.
`timescale 1ns / 1ps

module lsac_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lsac_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lsac_pkg::CSR_WIDTH-1:0]   csr_wdata,
   output lsac_pkg::cfg_type                cfg
);

   lsac_pkg::cfg_type cfg_ff;
   lsac_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (lsac_pkg::csr_index_type'(csr_index))
            lsac_pkg::CSR_WEIGHT_LOW:    cfg_in.weight_low  = csr_wdata;
            lsac_pkg::CSR_WEIGHT_MID:    cfg_in.weight_mid  = csr_wdata;
            lsac_pkg::CSR_WEIGHT_HIGH:   cfg_in.weight_high = csr_wdata;
            lsac_pkg::CSR_FEATURE_COUNT:
               cfg_in.feature_count = csr_wdata[lsac_pkg::FCOUNT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.weight_low    <= '0;
         cfg_ff.weight_mid    <= '0;
         cfg_ff.weight_high   <= '0;
         cfg_ff.feature_count <= lsac_pkg::FEATURE_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/lsac_ctrl.sv]
// Sequencer for the score counter: one multiply-accumulate per item, then the
// sigmoid steps at row end. Depends on lsac_pkg.
`timescale 1ns / 1ps

module lsac_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  lsac_pkg::status_type status,
   output lsac_pkg::cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_MAC   = 9'b000000010,
      S_SAT   = 9'b000000100,
      S_SQ    = 9'b000001000,
      S_CUBE  = 9'b000010000,
      S_LIN   = 9'b000100000,
      S_CTERM = 9'b001000000,
      S_SCORE = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      unique case (state_ff)
         S_IDLE:  state_in = (req_tvalid) ? S_MAC : S_IDLE;
         S_MAC:   state_in = (status.row_last) ? S_SAT : S_IDLE;
         S_SAT:   state_in = S_SQ;
         S_SQ:    state_in = S_CUBE;
         S_CUBE:  state_in = S_LIN;
         S_LIN:   state_in = S_CTERM;
         S_CTERM: state_in = S_SCORE;
         S_SCORE: state_in = S_OUT;
         S_OUT:   state_in = (status.out_free) ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd.load   = req_tvalid && (state_ff == S_IDLE);
      cmd.mac    = (state_ff == S_MAC);
      cmd.sat    = (state_ff == S_SAT);
      cmd.square = (state_ff == S_SQ);
      cmd.cube   = (state_ff == S_CUBE);
      cmd.linear = (state_ff == S_LIN);
      cmd.cterm  = (state_ff == S_CTERM);
      cmd.score  = (state_ff == S_SCORE);
      cmd.emit   = (state_ff == S_OUT) && status.out_free;
   end

endmodule

[rtl/lsac_dp.sv]
// Datapath: feature position, accumulator, cubic sigmoid steps, row counters
// and the result register. Depends on lsac_pkg.
`timescale 1ns / 1ps

module lsac_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lsac_pkg::cfg_type                      cfg,
   input  lsac_pkg::cmd_type                      cmd,
   input  logic signed [lsac_pkg::FEATURE_WIDTH-1:0] req_feature,
   input  logic                                   req_label,
   input  logic                                   rsp_tready,
   output lsac_pkg::status_type                   status,
   output logic                                   rsp_tvalid,
   output logic [lsac_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   localparam int FW      = lsac_pkg::FEATURE_WIDTH;
   localparam int WW      = lsac_pkg::WEIGHT_WIDTH;
   localparam int AW      = lsac_pkg::ACC_WIDTH;
   localparam int PW      = lsac_pkg::POS_W;
   localparam int CW      = lsac_pkg::COUNT_WIDTH;
   localparam int PROD_W  = FW + WW;
   localparam int XC_W    = 20;
   localparam int X_W     = XC_W + 4;
   localparam int SQ_W    = 32;
   localparam int CUBE_W  = 40;
   localparam int LIN_C_W = 23;
   localparam int CUB_C_W = 18;
   localparam int LIN_W   = X_W + LIN_C_W - 24;
   localparam int CT_W    = CUBE_W + CUB_C_W - 24;
   localparam int SUM_W   = 36;
   localparam int SC_W    = lsac_pkg::SCORE_W;

   localparam logic signed [AW-1:0] X_MAX = AW'(2**(XC_W-1) - 1);
   localparam logic signed [AW-1:0] X_MIN = AW'(-(2**(XC_W-1)));
   localparam logic signed [LIN_C_W-1:0] C_LIN  = LIN_C_W'(3305112);
   localparam logic signed [CUB_C_W-1:0] C_CUBE = CUB_C_W'(67109);
   localparam logic signed [SUM_W-1:0] C_HALF    = SUM_W'(32768);
   localparam logic signed [SUM_W-1:0] SCORE_MAX = SUM_W'(2**(SC_W-1) - 1);
   localparam logic signed [SUM_W-1:0] SCORE_MIN = SUM_W'(-(2**(SC_W-1)));
   localparam logic signed [SC_W:0] LABEL_ONE = (SC_W+1)'(65536);
   localparam logic signed [SC_W:0] HALF_POS  = (SC_W+1)'(32768);
   localparam logic signed [SC_W:0] HALF_NEG  = (SC_W+1)'(-32768);
   localparam logic [PW-1:0] POS_LAST  = PW'(lsac_pkg::MAX_FEATURES - 1);
   localparam logic [PW-1:0] POS_WORD1 = PW'(lsac_pkg::WEIGHTS_PER_WORD);
   localparam logic [PW-1:0] POS_WORD2 = PW'(2 * lsac_pkg::WEIGHTS_PER_WORD);
   localparam logic [lsac_pkg::FCOUNT_W-1:0] CNT_MAX =
      lsac_pkg::FCOUNT_W'(lsac_pkg::MAX_FEATURES);

   logic signed [FW-1:0]     feat_ff, feat_in;
   logic signed [WW-1:0]     weight_ff, weight_in;
   logic                     label_ff, label_in;
   logic [PW-1:0]            pos_ff, pos_in;
   logic [AW-1:0]            acc_ff, acc_in;
   logic signed [X_W-1:0]    x_ff, x_in;
   logic signed [SQ_W-1:0]   sq_ff, sq_in;
   logic signed [CUBE_W-1:0] cube_ff, cube_in;
   logic signed [LIN_W-1:0]  lin_ff, lin_in;
   logic signed [CT_W-1:0]   ct_ff, ct_in;
   logic signed [SC_W-1:0]   score_ff, score_in;
   logic [CW-1:0]            cc_ff, cc_in;
   logic [CW-1:0]            rc_ff, rc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [lsac_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [PW-1:0]                    pos_eff;
   logic [lsac_pkg::FCOUNT_W-1:0]    count_eff;
   logic [lsac_pkg::CSR_WIDTH-1:0]   word_sel;
   logic signed [WW-1:0]             weight_sel;
   logic signed [PROD_W-1:0]         prod;
   logic signed [AW-1:0]             acc_sh;
   logic signed [AW-1:0]             xc;
   logic signed [2*X_W-1:0]          sq_full;
   logic signed [SQ_W+X_W-1:0]       cube_full;
   logic signed [X_W+LIN_C_W-1:0]    lin_full;
   logic signed [CUBE_W+CUB_C_W-1:0] ct_full;
   logic signed [SUM_W-1:0]          sum;
   logic signed [SC_W:0]             diff;
   logic                             ok;

   // Clamp position and count to the legal range, pick the weight
   always_comb begin
      pos_eff = (pos_ff > POS_LAST) ? POS_LAST : pos_ff;
      if (cfg.feature_count == '0) begin
         count_eff = lsac_pkg::FCOUNT_W'(1);
      end else if (cfg.feature_count > CNT_MAX) begin
         count_eff = CNT_MAX;
      end else begin
         count_eff = cfg.feature_count;
      end
      priority if (pos_eff < POS_WORD1) begin
         word_sel = cfg.weight_low;
      end else if (pos_eff < POS_WORD2) begin
         word_sel = cfg.weight_mid;
      end else begin
         word_sel = cfg.weight_high;
      end
      weight_sel = word_sel[pos_eff[1:0] * WW +: WW];
   end

   assign status.row_last = ({1'b0, pos_eff} + (PW+1)'(1)) >= (PW+1)'(count_eff);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      prod      = feat_ff * weight_ff;
      acc_sh    = $signed(acc_ff) >>> 12;
      if (acc_sh > X_MAX) begin
         xc = X_MAX;
      end else if (acc_sh < X_MIN) begin
         xc = X_MIN;
      end else begin
         xc = acc_sh;
      end
      sq_full   = x_ff * x_ff;
      cube_full = sq_ff * x_ff;
      lin_full  = x_ff * C_LIN;
      ct_full   = cube_ff * C_CUBE;
      sum       = C_HALF + SUM_W'(lin_ff) - SUM_W'(ct_ff);
      diff      = (SC_W+1)'(score_ff) - (label_ff ? LABEL_ONE : '0);
      ok        = (diff > HALF_NEG) && (diff < HALF_POS);
   end

   always_comb begin
      feat_in      = feat_ff;
      weight_in    = weight_ff;
      label_in     = label_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      sq_in        = sq_ff;
      cube_in      = cube_ff;
      lin_in       = lin_ff;
      ct_in        = ct_ff;
      score_in     = score_ff;
      cc_in        = cc_ff;
      rc_in        = rc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         feat_in   = req_feature;
         weight_in = weight_sel;
         label_in  = req_label;
      end
      if (cmd.mac) begin
         acc_in = acc_ff + AW'(prod);
         if (!status.row_last) begin
            pos_in = pos_eff + PW'(1);
         end
      end
      if (cmd.sat) begin
         x_in   = {xc[XC_W-1:0], 4'b0000};
         acc_in = '0;
         pos_in = '0;
      end
      if (cmd.square) begin
         sq_in = sq_full[2*X_W-1:16];
      end
      if (cmd.cube) begin
         cube_in = cube_full[SQ_W+X_W-1:16];
      end
      if (cmd.linear) begin
         lin_in = lin_full[X_W+LIN_C_W-1:24];
      end
      if (cmd.cterm) begin
         ct_in = ct_full[CUBE_W+CUB_C_W-1:24];
      end
      if (cmd.score) begin
         if (sum > SCORE_MAX) begin
            score_in = SCORE_MAX[SC_W-1:0];
         end else if (sum < SCORE_MIN) begin
            score_in = SCORE_MIN[SC_W-1:0];
         end else begin
            score_in = sum[SC_W-1:0];
         end
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         if (ok && (cc_ff != '1)) begin
            cc_in = cc_ff + CW'(1);
         end
         if (rc_ff != '1) begin
            rc_in = rc_ff + CW'(1);
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = lsac_pkg::RSP_DATA_W'({rc_in, cc_in, ok, score_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         acc_ff       <= '0;
         cc_ff        <= '0;
         rc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         cc_ff        <= cc_in;
         rc_ff        <= rc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      feat_ff     <= feat_in;
      weight_ff   <= weight_in;
      label_ff    <= label_in;
      x_ff        <= x_in;
      sq_ff       <= sq_in;
      cube_ff     <= cube_in;
      lin_ff      <= lin_in;
      ct_ff       <= ct_in;
      score_ff    <= score_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("result register not loaded after emit");

   a_counts_ordered: assert property (@(posedge clock) disable iff (reset)
      cc_ff <= rc_ff)
      else $error("correct count exceeds row count");

   a_row_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.sat |=> (acc_ff == '0) && (pos_ff == '0))
      else $error("accumulator or position not cleared at row end");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("feature position out of range");

endmodule

[rtl/logistic_score_accuracy_counter_top.sv]
// Logistic score accuracy counter: top level joining registers, sequencer and datapath.
// Depends on lsac_pkg, lsac_csr, lsac_ctrl and lsac_dp.
// An item that does not end a row passes the accept and multiply-accumulate steps.
// A row's last item then passes six sigmoid steps and the output step, which holds
// while the result register is full. Reset (synchronous, active high) clears all state
// but the datapath value registers; the feature count returns to 9.
`timescale 1ns / 1ps

module logistic_score_accuracy_counter_top (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata fields from bit 0: feature_value
   input  logic [lsac_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser fields from bit 0: label_bit
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata fields from bit 0: score, correct, correct_total, rows_total, zero pad
   output logic [lsac_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [lsac_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lsac_pkg::CSR_WIDTH-1:0]      csr_wdata
);

   lsac_pkg::cfg_type    cfg;
   lsac_pkg::cmd_type    cmd;
   lsac_pkg::status_type status;

   // Weight words and feature count; writes land at once, no read-back
   lsac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer: take an item only when idle, walk the sigmoid steps at row end,
   // hold in the output step while the result register is still full
   lsac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath; the result register parts the two sides, so new items are taken
   // while a finished result still waits for rsp_tready
   lsac_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .req_feature ($signed(req_tdata[lsac_pkg::FEATURE_WIDTH-1:0])),
      .req_label   (req_tuser),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
